@@ sv/http_chunked_body_decoder_unit_macros.svh @@
// Assertion macros shared by the checker of the chunked body decoder.
// Depends on nothing; the user supplies i_clk and i_rst_n in scope.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HCBD_CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HCBD_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after reset is sampled low.
`define HCBD_CHK_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) else $error(msg);

`endif

@@ sv/hcbd_pkg.sv @@
// Types and constants of the chunked body decoder.
// Depends on nothing; used by every module of the block.
`default_nettype none
package hcbd_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_FIELD_W = BYTE_W + STATUS_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int HEX_DIGIT_W = 4;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]      data;
        logic                   last;
        logic                   is_cr;
        logic                   is_lf;
        logic                   is_ws;
        logic                   is_hex;
        logic [HEX_DIGIT_W-1:0] hex_val;
    } t_cls;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                byte_valid;
        logic                msg_done;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  total_len;
    } t_res;

endpackage
`default_nettype wire

@@ sv/hcbd_front.sv @@
// Front part of the decoder: accepts message words and classifies each byte.
// Depends on hcbd_pkg; feeds hcbd_queue.
`default_nettype none
module hcbd_front (
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [hcbd_pkg::BYTE_W-1:0] s_axis_tdata,
    input  wire logic                       s_axis_tlast,
    input  wire logic                       i_q_full,
    output logic                            o_push,
    output hcbd_pkg::t_cls                  o_item
);
    import hcbd_pkg::*;

    logic [BYTE_W-1:0] c;

    assign c             = s_axis_tdata;
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_item.data    = c;
        o_item.last    = s_axis_tlast;
        o_item.is_cr   = (c == CH_CR);
        o_item.is_lf   = (c == CH_LF);
        o_item.is_ws   = (c == 8'h20) || (c == 8'h09) || (c == CH_LF) || (c == 8'h0B)
                      || (c == 8'h0C) || (c == CH_CR);
        o_item.is_hex  = 1'b0;
        o_item.hex_val = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            o_item.is_hex  = 1'b1;
            o_item.hex_val = c[HEX_DIGIT_W-1:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            o_item.is_hex  = 1'b1;
            o_item.hex_val = c[HEX_DIGIT_W-1:0] + 4'd9;
        end
    end

endmodule
`default_nettype wire

@@ sv/hcbd_queue.sv @@
// Short queue of classified bytes between the front and back parts.
// Depends on hcbd_pkg.
`default_nettype none
module hcbd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hcbd_pkg::t_cls i_item,
    input  wire logic          i_pop,
    output hcbd_pkg::t_cls     o_head,
    output logic               o_avail,
    output logic               o_full
);
    import hcbd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls            r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_avail = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

@@ sv/hcbd_back.sv @@
// Back part of the decoder: size line parser, chunk tracker and output register.
// Depends on hcbd_pkg; fed by hcbd_queue.
`default_nettype none
module hcbd_back #(
    parameter int LINE_MAX = 15,
    parameter int LEN_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hcbd_pkg::t_cls              i_item,
    input  wire logic                        i_avail,
    output logic                             o_pop,
    input  wire logic                        i_cfg_valid,
    input  wire logic [hcbd_pkg::COUNT_W-1:0] i_cfg_data,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output hcbd_pkg::t_res                   o_res
);
    import hcbd_pkg::*;

    localparam int LC_W = $clog2(LINE_MAX + 1);
    localparam int CMP_W = (LEN_BITS > COUNT_W) ? LEN_BITS : COUNT_W;

    typedef enum logic [2:0] {
        PH_LINE, PH_SKIP, PH_OPTLF, PH_DATA, PH_DRAIN, PH_SKIP_OVF, PH_OPTLF_OVF, PH_DATA_OVF
    } t_phase;

    typedef enum logic [1:0] {
        HM_WS, HM_DIGITS, HM_STOP
    } t_hex_mode;

    t_phase              r_phase, n_phase;
    t_hex_mode           r_hex_mode, n_hex_mode;
    logic                r_pending_cr, n_pending_cr;
    logic [LC_W-1:0]     r_line_chars, n_line_chars;
    logic [LEN_BITS-1:0] r_size_acc, n_size_acc;
    logic [LEN_BITS-1:0] r_bytes_left, n_bytes_left;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic [COUNT_W-1:0]  r_capacity;
    logic                r_out_valid;
    t_res                r_res;

    t_hex_mode           feed_mode;
    logic [LEN_BITS-1:0] feed_size;
    logic [LC_W-1:0]     lc_inc;
    logic [LEN_BITS-1:0] line_size;
    logic [COUNT_W-1:0]  room;
    logic                chunk_ovf;
    logic [LEN_BITS-1:0] bl_dec;
    logic                data_ovf;
    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic                fin_byte;
    logic                plain;
    t_res                res;

    assign o_pop   = i_avail && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    // Hexadecimal size accumulation with saturation.
    always_comb begin
        feed_mode = r_hex_mode;
        feed_size = r_size_acc;
        if (r_hex_mode == HM_WS && i_item.is_ws) begin
            feed_mode = r_hex_mode;
        end else if (r_hex_mode == HM_STOP || !i_item.is_hex) begin
            feed_mode = HM_STOP;
        end else begin
            feed_mode = HM_DIGITS;
            if (r_size_acc[LEN_BITS-1 -: HEX_DIGIT_W] != '0) begin
                feed_size = '1;
            end else begin
                feed_size = {r_size_acc[LEN_BITS-HEX_DIGIT_W-1:0], i_item.hex_val};
            end
        end
    end

    assign lc_inc     = r_line_chars + 1'b1;
    assign line_size  = i_item.is_cr ? r_size_acc : feed_size;
    assign room       = r_capacity - r_out_count;
    assign chunk_ovf  = (r_out_count > r_capacity) || (CMP_W'(line_size) > CMP_W'(room));
    assign bl_dec     = r_bytes_left - LEN_BITS'(r_bytes_left != '0);
    assign data_ovf   = (r_phase == PH_OPTLF_OVF) || (r_phase == PH_DATA_OVF);

    always_comb begin
        n_phase      = r_phase;
        n_hex_mode   = r_hex_mode;
        n_pending_cr = r_pending_cr;
        n_line_chars = r_line_chars;
        n_size_acc   = r_size_acc;
        n_bytes_left = r_bytes_left;
        n_out_count  = r_out_count;
        fin          = 1'b0;
        fin_status   = ST_OK;
        fin_byte     = 1'b0;
        plain        = 1'b0;
        case (r_phase)
            PH_LINE: begin
                if (r_pending_cr) begin
                    n_pending_cr = 1'b0;
                    fin          = !i_item.is_lf || i_item.last;
                end else if (i_item.is_cr) begin
                    if (r_line_chars == '0) begin
                        fin          = i_item.last;
                        n_pending_cr = !i_item.last;
                    end else if (r_size_acc == '0) begin
                        fin = 1'b1;
                    end else begin
                        n_bytes_left = line_size;
                        n_phase      = chunk_ovf ? PH_OPTLF_OVF : PH_OPTLF;
                        fin          = i_item.last;
                        fin_status   = ST_TRUNC;
                    end
                end else begin
                    n_hex_mode   = feed_mode;
                    n_size_acc   = feed_size;
                    n_line_chars = lc_inc;
                    if (lc_inc >= LC_W'(LINE_MAX)) begin
                        if (feed_size == '0) begin
                            fin = 1'b1;
                        end else begin
                            n_bytes_left = line_size;
                            n_phase      = chunk_ovf ? PH_SKIP_OVF : PH_SKIP;
                            fin          = i_item.last;
                            fin_status   = ST_TRUNC;
                        end
                    end else begin
                        fin        = i_item.last;
                        fin_status = (feed_size == '0) ? ST_OK : ST_TRUNC;
                    end
                end
            end
            PH_SKIP, PH_SKIP_OVF: begin
                n_phase    = (r_phase == PH_SKIP) ? PH_OPTLF : PH_OPTLF_OVF;
                fin        = i_item.last;
                fin_status = ST_TRUNC;
            end
            PH_DRAIN: begin
                n_phase = r_phase;
            end
            PH_OPTLF, PH_OPTLF_OVF, PH_DATA, PH_DATA_OVF: begin
                if ((r_phase == PH_OPTLF || r_phase == PH_OPTLF_OVF) && i_item.is_lf) begin
                    n_phase    = data_ovf ? PH_DATA_OVF : PH_DATA;
                    fin        = i_item.last;
                    fin_status = ST_TRUNC;
                end else begin
                    n_phase      = data_ovf ? PH_DATA_OVF : PH_DATA;
                    n_out_count  = r_out_count + COUNT_W'(!data_ovf);
                    n_bytes_left = bl_dec;
                    if (bl_dec == '0) begin
                        if (data_ovf) begin
                            fin        = 1'b1;
                            fin_status = ST_OVF;
                        end else begin
                            n_phase      = PH_LINE;
                            n_pending_cr = 1'b0;
                            n_hex_mode   = HM_WS;
                            n_line_chars = '0;
                            n_size_acc   = '0;
                            fin          = i_item.last;
                            fin_byte     = 1'b1;
                            plain        = !i_item.last;
                        end
                    end else begin
                        fin        = i_item.last;
                        fin_status = ST_TRUNC;
                        fin_byte   = !data_ovf;
                        plain      = !i_item.last && !data_ovf;
                    end
                end
            end
            default: begin
                n_phase = PH_LINE;
            end
        endcase

        res.out_byte   = ((fin && fin_byte) || plain) ? i_item.data : '0;
        res.byte_valid = (fin && fin_byte) || plain;
        res.msg_done   = fin;
        res.status     = fin ? fin_status : ST_OK;
        res.total_len  = n_out_count;

        if (fin && !i_item.last) begin
            n_phase = PH_DRAIN;
        end
        if ((fin || r_phase == PH_DRAIN) && i_item.last) begin
            n_phase      = PH_LINE;
            n_pending_cr = 1'b0;
            n_hex_mode   = HM_WS;
            n_line_chars = '0;
            n_size_acc   = '0;
            n_bytes_left = '0;
            n_out_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LINE;
            r_hex_mode   <= HM_WS;
            r_pending_cr <= 1'b0;
            r_line_chars <= '0;
            r_size_acc   <= '0;
            r_bytes_left <= '0;
            r_out_count  <= '0;
            r_capacity   <= '1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (o_pop) begin
                r_phase      <= n_phase;
                r_hex_mode   <= n_hex_mode;
                r_pending_cr <= n_pending_cr;
                r_line_chars <= n_line_chars;
                r_size_acc   <= n_size_acc;
                r_bytes_left <= n_bytes_left;
                r_out_count  <= n_out_count;
            end
            if (o_pop && (fin || plain)) begin
                r_out_valid <= 1'b1;
                r_res       <= res;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/http_chunked_body_decoder_unit.sv @@
// Top level of the chunked body decoder: front classifier, queue and back engine.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue and hcbd_back.
//
//   Channel   Direction  Handshake                      Word
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata = in_byte, tlast = last_byte
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata, tlast = msg_done,
//                                                       tuser = byte_valid
//   cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_data = out_capacity
//
// One byte is taken per cycle while the queue is not full; a result passes the queue and the output register.
// The back engine updates its chunk state once per cycle while it can pop a byte, which sets the rate.
// Reset is synchronous and active low; capacity returns to all ones.
// An output stall stops the back engine; the front keeps accepting until the queue is full.
`default_nettype none
module http_chunked_body_decoder_unit #(
    parameter int LINE_MAX    = 15,
    parameter int LEN_BITS    = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] in_byte
    input  wire logic [hcbd_pkg::BYTE_W-1:0]      s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [7:0] out_byte, [9:8] status, [41:10] total_len, [47:42] zero
    output logic [hcbd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,
    // [0] byte_valid
    output logic                                 m_axis_tuser,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [hcbd_pkg::COUNT_W-1:0]     i_cfg_data
);
    import hcbd_pkg::*;

    logic q_full;
    logic q_push;
    logic q_avail;
    logic q_pop;
    t_cls push_item;
    t_cls head_item;
    t_res res;

    assign o_cfg_ready = 1'b1;

    hcbd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_item        (push_item)
    );

    hcbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_head  (head_item),
        .o_avail (q_avail),
        .o_full  (q_full)
    );

    hcbd_back #(
        .LINE_MAX (LINE_MAX),
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (head_item),
        .i_avail     (q_avail),
        .o_pop       (q_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                           res.total_len, res.status, res.out_byte};
    assign m_axis_tlast = res.msg_done;
    assign m_axis_tuser = res.byte_valid;

endmodule
`default_nettype wire

@@ sv/hcbd_checker.sv @@
// Port-level checker of the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg and http_chunked_body_decoder_unit_macros.svh.
`default_nettype none
`include "http_chunked_body_decoder_unit_macros.svh"
module hcbd_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [hcbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                       m_axis_tlast,
    input wire logic                       m_axis_tuser
);
    import hcbd_pkg::*;

    `HCBD_CHK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
    `HCBD_CHK_SAME(a_plain_is_byte, m_axis_tvalid && !m_axis_tlast, m_axis_tuser && (m_axis_tdata[9:8] == ST_OK), "word without status carries no byte or a status")
    `HCBD_CHK_SAME(a_ovf_no_byte, m_axis_tvalid && m_axis_tlast && (m_axis_tdata[9:8] == ST_OVF), !m_axis_tuser, "overflow status carries a byte")
    `HCBD_CHK_RESET(a_reset_idle, !m_axis_tvalid, "word shown right after reset")

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (.*);
`default_nettype wire
